[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes for the sorted priority queue
// Command and result item layouts, stored entry layout, command and status
// codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int TagW   = 16;
    localparam int SizeW  = 32;
    localparam int TimeW  = 32;
    localparam int StatW  = 2;
    localparam int CountW = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [StatW-1:0] ST_DONE  = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [TagW-1:0]  file_tag;
        logic [SizeW-1:0] file_size;
        logic [TimeW-1:0] file_time;
    } t_cmd_item;

    typedef struct packed {
        logic [StatW-1:0]  status;
        logic [TagW-1:0]   popped_tag;
        logic [SizeW-1:0]  popped_size;
        logic [TimeW-1:0]  popped_time;
        logic [CountW-1:0] entry_count;
    } t_result_item;

    typedef struct packed {
        logic [TagW-1:0]  tag;
        logic [SizeW-1:0] size;
        logic [TimeW-1:0] stamp;
    } t_entry;

    // per-cycle instruction broadcast to every cell
    typedef struct packed {
        logic shift_in;   // insert, queue not full
        logic shift_out;  // pop, queue not empty
    } t_cell_op;

endpackage

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted queue
// Holds one entry, compares it with the broadcast key and either keeps it,
// takes the new entry, takes its left neighbor's entry or its right one's.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  logic     i_occupied,
    input  t_entry   i_new,
    input  t_entry   i_prev,
    input  logic     i_prev_ahead,
    input  t_entry   i_next,
    output t_entry   o_entry,
    output logic     o_ahead
);

    t_entry r_entry;
    t_entry n_entry;

    // an equal key stays ahead so equal keys leave first-in
    assign o_ahead = i_occupied &&
        ((r_entry.size < i_new.size) ||
         ((r_entry.size == i_new.size) && (r_entry.stamp <= i_new.stamp)));

    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_op.shift_in) begin
            if (!o_ahead) begin
                n_entry = i_prev_ahead ? i_new : i_prev;
            end
        end else if (i_op.shift_out) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hdl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded queue kept sorted by size, then timestamp
// A row of slot cells; every cell compares against the new key at once.
//
//   channel   ports                          direction  handshake
//   command   start, busy, i_cmd             in         start && !busy
//   result    o_done, o_result               out        o_done strobe
//
// One command per cycle; busy is never raised.
// The result appears in the cycle after the command, with o_done high for
// exactly that cycle; the receiver cannot stall it.
// The slot compare in every cell sets the cycle; there is no iteration.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_cmd,
    output logic         o_done,
    output t_result_item o_result
);

    localparam int CntW = $clog2(P_DEPTH + 1);

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_done;
    t_result_item    r_result;
    t_result_item    n_result;

    t_cell_op        op;
    t_entry          new_entry;
    t_entry          cell_entry [P_DEPTH];
    logic            cell_ahead [P_DEPTH];
    logic            accept;
    logic            full;
    logic            empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CntW'(P_DEPTH));
    assign empty  = (r_count == '0);

    assign new_entry.tag   = i_cmd.file_tag;
    assign new_entry.size  = i_cmd.file_size;
    assign new_entry.stamp = i_cmd.file_time;

    assign op.shift_in  = accept && (i_cmd.cmd == CMD_INSERT) && !full;
    assign op.shift_out = accept && (i_cmd.cmd == CMD_POP) && !empty;

    genvar g;
    generate
        for (g = 0; g < P_DEPTH; g++) begin : g_cell
            t_entry prev_entry;
            t_entry next_entry;
            logic   prev_ahead;

            if (g == 0) begin : g_head
                assign prev_entry = '0;
                assign prev_ahead = 1'b1;
            end else begin : g_body
                assign prev_entry = cell_entry[g-1];
                assign prev_ahead = cell_ahead[g-1];
            end

            if (g == P_DEPTH - 1) begin : g_tail
                assign next_entry = '0;
            end else begin : g_link
                assign next_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_op         (op),
                .i_occupied   (CntW'(g) < r_count),
                .i_new        (new_entry),
                .i_prev       (prev_entry),
                .i_prev_ahead (prev_ahead),
                .i_next       (next_entry),
                .o_entry      (cell_entry[g]),
                .o_ahead      (cell_ahead[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        if (op.shift_in) begin
            n_count = r_count + CntW'(1);
        end else if (op.shift_out) begin
            n_count              = r_count - CntW'(1);
            n_result.popped_tag  = cell_entry[0].tag;
            n_result.popped_size = cell_entry[0].size;
            n_result.popped_time = cell_entry[0].stamp;
        end

        if (i_cmd.cmd == CMD_INSERT) begin
            n_result.status = full ? ST_FULL : ST_DONE;
        end else begin
            n_result.status = empty ? ST_EMPTY : ST_DONE;
        end

        // the count field keeps only its low bits
        n_result.entry_count = CountW'(32'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
